// File: sv/fwq_pkg.sv
// ----------------------------------------------------------------------------
// fwq_pkg
// Types and constants shared by the futex wait queue core.
// ----------------------------------------------------------------------------
package fwq_pkg;

  localparam int WAITERS  = 16;
  localparam int KEY_BITS = 48;
  localparam int SLOT_W   = $clog2(WAITERS);
  localparam int CNT_W    = $clog2(WAITERS + 1);

  localparam logic [2:0] OP_WAIT = 3'd0;
  localparam logic [2:0] OP_WAKE = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_INTR = 3'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_AGAIN    = 3'd1;
  localparam logic [2:0] ST_TIMEDOUT = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_INTR     = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [2:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [7:0]          waiter_id;
    logic [31:0]         value;
    logic [31:0]         current_value;
    logic                has_timeout;
    logic [31:0]         timeout_us;
  } fwq_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] released_id;
    logic [2:0] status;
    logic [4:0] woken_count;
    logic       last;
  } fwq_out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [7:0]          waiter;
    logic                timed;
    logic [31:0]         remaining;
  } fwq_slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_REPLY
  } fwq_state_t;

endpackage

// File: sv/futex_wait_queue_core.sv
// ----------------------------------------------------------------------------
// futex_wait_queue_core
// Flat table of waiting threads kept in arrival order in one slot memory.
// ----------------------------------------------------------------------------
// Every request walks the occupied slots of a single-port-read slot memory,
// one slot per cycle while the output register is free, with a registered
// read, compacting the table as it goes (read slot r, write the survivor back
// at slot w). A request starts the walk, reads each occupied slot, closes the
// walk and then finishes. Requests with a bad op, a bad wait or wake key,
// or a wait whose value mismatches or whose timeout is zero skip the walk.
// Releases and replies leave through a one-entry output register, and the walk
// stalls in any cycle in which that register holds a transaction that is not
// taken. Tick and interrupt releases wait one step in a hold register so the
// final one can carry last. The occupancy count lives in flip-flops; the slot
// contents live in the memory.
// ----------------------------------------------------------------------------
module futex_wait_queue_core
  import fwq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fwq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fwq_out_t out_data
);

  fwq_slot_t mem [WAITERS];
  fwq_slot_t rd_data_r;

  fwq_state_t state_r, state_nxt;
  fwq_in_t    req_r;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;      // next slot to issue a read for
  logic [CNT_W-1:0] w_r, w_nxt;        // compaction write pointer
  logic             pend_r, pend_nxt;  // read data for slot rd_r-1 is valid
  logic [31:0]      left_r, left_nxt;
  logic [4:0]       woken_r, woken_nxt;
  logic             dup_r, dup_nxt;
  logic             found_r, found_nxt;
  logic             ov_r, ov_nxt;
  fwq_out_t         od_r, od_nxt;

  logic             rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_addr;
  fwq_slot_t        wr_data;

  logic      out_free;
  logic      key_bad;
  logic      acc;
  fwq_slot_t cur;
  logic [31:0] dec;
  logic      match;
  logic      expire;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_free  = !ov_r || out_ready;
  assign key_bad   = req_r.key[1:0] != 2'b00;
  assign cur       = rd_data_r;
  assign dec       = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : 32'd0;

  always_comb begin
    match = 1'b0;
    expire = 1'b0;
    case (req_r.op)
      OP_WAKE: match = (left_r != 32'd0) && (cur.key == req_r.key);
      OP_TICK: begin
        expire = cur.timed && (dec == 32'd0);
        match  = expire;
      end
      OP_INTR: match = !found_r && (cur.waiter == req_r.waiter_id);
      default: match = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc) state_nxt = S_SCAN;
      S_SCAN:  if (out_free && !pend_r && rd_r == n_r) state_nxt = S_TAIL;
      S_TAIL:  if (out_free) state_nxt = S_IDLE;
      S_REPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt = n_r;  rd_nxt = rd_r;  w_nxt = w_r;  pend_nxt = pend_r;
    left_nxt = left_r;  woken_nxt = woken_r;  dup_nxt = dup_r;
    found_nxt = found_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    rd_en = 1'b0;  rd_addr = rd_r[SLOT_W-1:0];
    wr_en = 1'b0;  wr_addr = w_r[SLOT_W-1:0];  wr_data = cur;
    case (state_r)
      S_IDLE: begin
        rd_nxt = '0;  w_nxt = '0;  pend_nxt = 1'b0;
        left_nxt = in_data.value;  woken_nxt = '0;
        dup_nxt = 1'b0;  found_nxt = 1'b0;
      end
      S_SCAN: begin
        if (out_free) begin
          // bad ops, bad wait/wake keys, value mismatches and zero timeouts skip the walk
          if (req_r.op > OP_INTR || (key_bad && (req_r.op == OP_WAIT ||
              req_r.op == OP_WAKE)) || (req_r.op == OP_WAIT &&
              (req_r.current_value != req_r.value ||
               (req_r.has_timeout && req_r.timeout_us == 32'd0)))) begin
            rd_nxt = n_r;  pend_nxt = 1'b0;
          end else begin
            if (pend_r) begin
              if (req_r.op == OP_WAIT) begin
                if (cur.waiter == req_r.waiter_id) dup_nxt = 1'b1;
                w_nxt = w_r + 1'b1;
              end else if (match) begin
                ov_nxt = 1'b1;
                od_nxt = '{kind: 1'b1, released_id: cur.waiter,
                           status: (req_r.op == OP_TICK) ? ST_TIMEDOUT :
                                   (req_r.op == OP_INTR) ? ST_INTR : ST_OK,
                           woken_count: 5'd0, last: 1'b0};
                if (req_r.op == OP_WAKE) begin
                  left_nxt  = left_r - 32'd1;
                  woken_nxt = woken_r + 5'd1;
                end
                if (req_r.op == OP_INTR) found_nxt = 1'b1;
              end else begin
                wr_en = 1'b1;
                wr_data = cur;
                if (req_r.op == OP_TICK && cur.timed) wr_data.remaining = dec;
                w_nxt = w_r + 1'b1;
              end
            end
            if (rd_r != n_r) begin
              rd_en = 1'b1;
              rd_nxt = rd_r + 1'b1;
              pend_nxt = 1'b1;
            end else begin
              pend_nxt = 1'b0;
            end
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          ov_nxt = 1'b0;
          od_nxt = '{kind: 1'b0, released_id: 8'd0, status: ST_OK,
                     woken_count: 5'd0, last: 1'b1};
          case (req_r.op)
            OP_WAIT: begin
              od_nxt.released_id = req_r.waiter_id;
              ov_nxt = 1'b1;
              if (key_bad) od_nxt.status = ST_INVALID;
              else if (req_r.current_value != req_r.value) od_nxt.status = ST_AGAIN;
              else if (req_r.has_timeout && req_r.timeout_us == 32'd0)
                od_nxt.status = ST_TIMEDOUT;
              else if (dup_r) od_nxt.status = ST_INVALID;
              else if (n_r == CNT_W'(WAITERS)) od_nxt.status = ST_FULL;
              else begin
                ov_nxt = 1'b0;
                wr_en = 1'b1;
                wr_addr = n_r[SLOT_W-1:0];
                wr_data = '{key: req_r.key, waiter: req_r.waiter_id,
                            timed: req_r.has_timeout,
                            remaining: req_r.has_timeout ? req_r.timeout_us : 32'd0};
                n_nxt = n_r + 1'b1;
              end
            end
            OP_WAKE: begin
              ov_nxt = 1'b1;
              if (key_bad) od_nxt.status = ST_INVALID;
              else begin
                od_nxt.woken_count = woken_r;
                n_nxt = w_r;
              end
            end
            OP_TICK: begin
              n_nxt = w_r;
              // mark a release still waiting in the output register as final
              if (ov_r && !out_ready && od_r.kind) begin
                ov_nxt = 1'b1;
                od_nxt = od_r;
                od_nxt.last = 1'b1;
              end else if (ov_r && out_ready) begin
                ov_nxt = 1'b0;
              end
            end
            OP_INTR: begin
              n_nxt = w_r;
              if (found_r) begin
                ov_nxt = 1'b0;
              end else begin
                ov_nxt = 1'b1;
                od_nxt.released_id = req_r.waiter_id;
                od_nxt.status = ST_INVALID;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              od_nxt.status = ST_INVALID;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Release for tick/interrupt must carry last on the final one; handled by
  // holding the newest release until the walk proves no later one follows.
  logic     hold_r, hold_nxt;
  fwq_out_t hd_r, hd_nxt;
  fwq_out_t send;
  logic     send_v;

  always_comb begin
    hold_nxt = hold_r;
    hd_nxt   = hd_r;
    send_v   = ov_nxt;
    send     = od_nxt;
    if ((req_r.op == OP_TICK || req_r.op == OP_INTR) && state_r != S_IDLE) begin
      send_v = 1'b0;
      send   = od_r;
      if (state_r == S_SCAN && ov_nxt && !(ov_r && !out_ready) && od_nxt.kind) begin
        // new release: push previous held one out, hold the new one
        send_v   = hold_r;
        send     = hd_r;
        hold_nxt = 1'b1;
        hd_nxt   = od_nxt;
      end else if (state_r == S_TAIL && out_free) begin
        send_v = hold_r || ov_nxt;
        send   = hold_r ? hd_r : od_nxt;
        send.last = 1'b1;
        hold_nxt = 1'b0;
      end else begin
        send_v = ov_r && !out_ready;
        send   = od_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0;  rd_r <= '0;  w_r <= '0;  pend_r <= 1'b0;
      ov_r <= 1'b0;  hold_r <= 1'b0;
      dup_r <= 1'b0;  found_r <= 1'b0;  woken_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;  rd_r <= rd_nxt;  w_r <= w_nxt;  pend_r <= pend_nxt;
      ov_r <= send_v;  hold_r <= hold_nxt;
      dup_r <= dup_nxt;  found_r <= found_nxt;  woken_r <= woken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) req_r <= in_data;
    left_r <= left_nxt;
    od_r   <= send;
    hd_r   <= hd_nxt;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(WAITERS)) else $error("occupancy above table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the futex wait queue core against an in-bench model of the waiter
// table: waits, wakes, ticks, interrupts and invalid ops are sent with random handshake
// gaps and receiver stalls, and every release or reply is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import fwq_pkg::*;

  localparam logic [2:0] OP_BAD_LO  = 3'd4;
  localparam int         RAND_ITEMS = 180;
  localparam int         QUIET_TAIL = 40;
  localparam int         HOLD_AT    = 70;
  localparam int         HOLD_LEN   = 300;

  class futex_scoreboard;
    fwq_slot_t waiters[WAITERS];
    int        n_waiting;
    fwq_out_t  pending_results[$];
    int        errors;

    function new();
      n_waiting = 0;
      errors    = 0;
    endfunction

    function fwq_out_t mk(logic kind, logic [7:0] id, logic [2:0] st,
                          logic [4:0] woken, logic last);
      fwq_out_t r;
      r.kind        = kind;
      r.released_id = id;
      r.status      = st;
      r.woken_count = woken;
      r.last        = last;
      return r;
    endfunction

    // Update the table for one accepted transaction and queue its results.
    function void note_request(fwq_in_t t);
      fwq_slot_t keep[$];
      fwq_out_t  outs[$];
      int        left;
      int        woken;
      int        hit;
      hit = -1;
      if (t.op >= OP_BAD_LO) begin
        pending_results.push_back(mk(1'b0, 8'd0, ST_INVALID, 5'd0, 1'b1));
      end else if (t.op == OP_WAIT) begin
        for (int i = 0; i < n_waiting; i++)
          if (waiters[i].waiter == t.waiter_id) hit = i;
        if (t.key[1:0] != 2'b00)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_INVALID, 5'd0, 1'b1));
        else if (t.current_value != t.value)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_AGAIN, 5'd0, 1'b1));
        else if (t.has_timeout && t.timeout_us == 32'd0)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_TIMEDOUT, 5'd0, 1'b1));
        else if (hit >= 0)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_INVALID, 5'd0, 1'b1));
        else if (n_waiting >= WAITERS)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_FULL, 5'd0, 1'b1));
        else begin
          waiters[n_waiting].key       = t.key;
          waiters[n_waiting].waiter    = t.waiter_id;
          waiters[n_waiting].timed     = t.has_timeout;
          waiters[n_waiting].remaining = t.has_timeout ? t.timeout_us : 32'd0;
          n_waiting++;
        end
      end else if (t.op == OP_WAKE) begin
        if (t.key[1:0] != 2'b00) begin
          pending_results.push_back(mk(1'b0, 8'd0, ST_INVALID, 5'd0, 1'b1));
        end else begin
          left  = (t.value > WAITERS) ? WAITERS : int'(t.value);
          woken = 0;
          for (int i = 0; i < n_waiting; i++) begin
            if (left != 0 && waiters[i].key == t.key) begin
              pending_results.push_back(mk(1'b1, waiters[i].waiter, ST_OK, 5'd0, 1'b0));
              left--;
              woken++;
            end else
              keep.push_back(waiters[i]);
          end
          pending_results.push_back(mk(1'b0, 8'd0, ST_OK, woken[4:0], 1'b1));
          n_waiting = keep.size();
          foreach (keep[i]) waiters[i] = keep[i];
        end
      end else if (t.op == OP_TICK) begin
        for (int i = 0; i < n_waiting; i++) begin
          if (waiters[i].timed && waiters[i].remaining != 0)
            waiters[i].remaining--;
          if (waiters[i].timed && waiters[i].remaining == 0)
            outs.push_back(mk(1'b1, waiters[i].waiter, ST_TIMEDOUT, 5'd0, 1'b0));
          else
            keep.push_back(waiters[i]);
        end
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) pending_results.push_back(outs[i]);
        n_waiting = keep.size();
        foreach (keep[i]) waiters[i] = keep[i];
      end else begin
        for (int i = 0; i < n_waiting; i++)
          if (hit < 0 && waiters[i].waiter == t.waiter_id) hit = i;
        if (hit < 0)
          pending_results.push_back(mk(1'b0, t.waiter_id, ST_INVALID, 5'd0, 1'b1));
        else begin
          pending_results.push_back(mk(1'b1, t.waiter_id, ST_INTR, 5'd0, 1'b1));
          for (int i = hit; i + 1 < n_waiting; i++) waiters[i] = waiters[i+1];
          n_waiting--;
        end
      end
    endfunction

    function void check_result(fwq_out_t got);
      fwq_out_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d status=%0d", got.kind,
               got.released_id, got.status);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.released_id !== exp_r.released_id) begin
        $error("released_id: expected %0d, got %0d", exp_r.released_id,
               got.released_id); errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
      end
      if (got.woken_count !== exp_r.woken_count) begin
        $error("woken_count: expected %0d, got %0d", exp_r.woken_count,
               got.woken_count); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  fwq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  fwq_out_t out_data;

  futex_scoreboard sb;
  bit quiet;
  bit hold_req;
  bit src_idle;

  futex_wait_queue_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    sb        = new();
  end

  // Send one transaction, optionally after a random idle burst.
  task automatic send(fwq_in_t t);
    if (!quiet && !src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(t);
  endtask

  function automatic fwq_in_t blank(logic [2:0] op);
    fwq_in_t t;
    t    = '0;
    t.op = op;
    return t;
  endfunction

  function automatic fwq_in_t wait_req(logic [47:0] key, logic [7:0] id,
                                       logic has_to, logic [31:0] to_us);
    fwq_in_t t;
    t               = blank(OP_WAIT);
    t.key           = key;
    t.waiter_id     = id;
    t.value         = $urandom;
    t.current_value = t.value;
    t.has_timeout   = has_to;
    t.timeout_us    = to_us;
    return t;
  endfunction

  function automatic fwq_in_t wake_req(logic [47:0] key, logic [31:0] cnt);
    fwq_in_t t;
    t       = blank(OP_WAKE);
    t.key   = key;
    t.value = cnt;
    return t;
  endfunction

  function automatic logic [47:0] pick_key();
    logic [47:0] k;
    case ($urandom_range(0, 9))
      0:       k = 48'({$urandom, $urandom});
      1:       k = 48'hFFFF_FFFF_FFFC;
      2:       k = 48'h0;
      default: k = 48'h1000 + 48'($urandom_range(0, 3)) * 4;
    endcase
    return k;
  endfunction

  function automatic fwq_in_t random_req();
    fwq_in_t      t;
    int           sel;
    logic [191:0] noise;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      t = wait_req(pick_key(),
                   ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23)),
                   $urandom_range(0, 2) != 0,
                   ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 12)));
      if ($urandom_range(0, 9) == 0) t.current_value = $urandom;
    end else if (sel < 62) begin
      t = wake_req(pick_key(),
                   ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 5)));
    end else if (sel < 87) begin
      t = blank(OP_TICK);
    end else if (sel < 95) begin
      t           = blank(OP_INTR);
      t.waiter_id = 8'($urandom_range(0, 23));
    end else begin
      // noise: every field random, ops of any value
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t     = noise[$bits(fwq_in_t)-1:0];
    end
    return t;
  endfunction

  initial begin
    fwq_in_t t;
    src_idle = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int b = 0; b < 4; b++) send(blank(OP_BAD_LO + 3'(b)));
    send(wait_req(48'h1002, 8'd1, 1'b0, 32'd0));
    t = wait_req(48'h1000, 8'd1, 1'b0, 32'd0);
    t.current_value = ~t.value;
    send(t);
    send(wait_req(48'h1000, 8'd1, 1'b1, 32'd0));
    send(wait_req(48'h1000, 8'd1, 1'b0, 32'd0));
    send(wait_req(48'h1000, 8'd1, 1'b0, 32'd0));
    send(wait_req(48'hFFFF_FFFF_FFFC, 8'd255, 1'b1, 32'd2));
    send(blank(OP_TICK));
    send(blank(OP_TICK));
    send(wake_req(48'h1001, 32'd1));
    send(wake_req(48'h1000, 32'd0));
    t = blank(OP_INTR);
    t.waiter_id = 8'd77;
    send(t);
    t.waiter_id = 8'd1;
    send(t);
    // fill the table, then one more is refused
    for (int i = 0; i < WAITERS + 1; i++)
      send(wait_req(48'h2000, 8'(10 + i), 1'b1, 32'hFFFF_FFFF));
    send(wake_req(48'h2000, 32'hFFFF_FFFF));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      src_idle = ($urandom_range(0, 3) == 0);
      send(random_req());
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4 * WAITERS + 20) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the core.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
